>>> hw/rtl/gstf_pkg.sv
// ----------------------------------------------------------------------------
// gstf_pkg
// Shared constants, command and status types and helpers of the sector
// triangle fan generator.
// ----------------------------------------------------------------------------
package gstf_pkg;

    localparam int ANG_W   = 15;
    localparam int SW_W    = 14;
    localparam int CRD_W   = 13;
    localparam int CFG_W   = 14;
    localparam int IDX_W   = 2;
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SC_W    = 20;
    localparam int OPC_W   = 5;
    localparam int STEP_W  = 5;

    localparam int STEP_ANGLE_DEF    = 80;
    localparam int MAX_TRIANGLES_DEF = 64;
    localparam int SWEEP_LIMIT       = 5120;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_CENTER_X    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_CENTER_Y    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_OUTER_RAD   = 2'd2;
    localparam logic [IDX_W-1:0] CFG_START_ANGLE = 2'd3;

    // angle to phase factor split into high and low parts (low part 18 bits)
    localparam logic [17:0] K_HI    = 18'd186319;
    localparam logic [10:0] K_LO    = 11'd1954;
    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // reciprocals ceil(2^36/d), exact floor division for 30-bit dividends
    localparam logic [MUL_W-1:0] M42 = 34'd1636178018;
    localparam logic [MUL_W-1:0] M20 = 34'd3435973837;
    localparam logic [MUL_W-1:0] M6  = 34'd11453246123;
    localparam logic [MUL_W-1:0] M56 = 34'd1227133514;
    localparam logic [MUL_W-1:0] M30 = 34'd2290649225;
    localparam logic [MUL_W-1:0] M12 = 34'd5726623062;
    // ceil(2^27/25), exact for dividends below 2^22
    localparam logic [22:0] M25      = 23'd5368710;
    localparam logic [45:0] RND_BIAS = 46'd104857600;

    // datapath operations
    localparam logic [OPC_W-1:0] OP_NOP = 5'd0;
    localparam logic [OPC_W-1:0] OP_PHH = 5'd1;
    localparam logic [OPC_W-1:0] OP_PHL = 5'd2;
    localparam logic [OPC_W-1:0] OP_X   = 5'd3;
    localparam logic [OPC_W-1:0] OP_X2  = 5'd4;
    localparam logic [OPC_W-1:0] OP_T42 = 5'd5;
    localparam logic [OPC_W-1:0] OP_T20 = 5'd6;
    localparam logic [OPC_W-1:0] OP_T6  = 5'd7;
    localparam logic [OPC_W-1:0] OP_T56 = 5'd8;
    localparam logic [OPC_W-1:0] OP_T30 = 5'd9;
    localparam logic [OPC_W-1:0] OP_T12 = 5'd10;
    localparam logic [OPC_W-1:0] OP_W   = 5'd11;
    localparam logic [OPC_W-1:0] OP_S   = 5'd12;
    localparam logic [OPC_W-1:0] OP_RX  = 5'd13;
    localparam logic [OPC_W-1:0] OP_AX  = 5'd14;
    localparam logic [OPC_W-1:0] OP_QX  = 5'd15;
    localparam logic [OPC_W-1:0] OP_RY  = 5'd16;
    localparam logic [OPC_W-1:0] OP_AY  = 5'd17;
    localparam logic [OPC_W-1:0] OP_QY  = 5'd18;

    localparam logic [STEP_W-1:0] PROG_CTR  = 5'd16;
    localparam logic [STEP_W-1:0] PROG_LAST = 5'd21;

    typedef struct packed {
        logic [OPC_W-1:0] op;
        logic             centre;
        logic             start;
        logic             advance;
        logic             emit;
        logic             last;
    } gstf_cmd_t;

    typedef struct packed {
        logic rem_zero;
        logic out_free;
    } gstf_stat_t;

    // one rim point: phase, sine chain, cosine chain, then x and y scaling
    function automatic logic [OPC_W-1:0] prog_op(input logic [STEP_W-1:0] step);
        logic [OPC_W-1:0] op;
        unique case (step)
            5'd0:    op = OP_PHH;
            5'd1:    op = OP_PHL;
            5'd2:    op = OP_X;
            5'd3:    op = OP_X2;
            5'd4:    op = OP_T42;
            5'd5:    op = OP_W;
            5'd6:    op = OP_T20;
            5'd7:    op = OP_W;
            5'd8:    op = OP_T6;
            5'd9:    op = OP_S;
            5'd10:   op = OP_T56;
            5'd11:   op = OP_W;
            5'd12:   op = OP_T30;
            5'd13:   op = OP_W;
            5'd14:   op = OP_T12;
            5'd15:   op = OP_W;
            5'd16:   op = OP_RX;
            5'd17:   op = OP_AX;
            5'd18:   op = OP_QX;
            5'd19:   op = OP_RY;
            5'd20:   op = OP_AY;
            5'd21:   op = OP_QY;
            default: op = OP_NOP;
        endcase
        return op;
    endfunction

    function automatic logic [15:0] pos_sat(input logic signed [SC_W-1:0] sc);
        logic signed [SC_W:0] v;
        logic [15:0]          r;
        v = SC_W'(sc) - (SC_W+1)'(16384);
        if (v > (SC_W+1)'(32767))
            r = 16'h7fff;
        else if (v < -(SC_W+1)'(32768))
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic [15:0] uv_sat(input logic signed [SC_W-1:0] sc);
        logic [15:0] r;
        if (sc < 0)
            r = 16'h0000;
        else if (sc > SC_W'(65535))
            r = 16'hffff;
        else
            r = sc[15:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/gauge_sector_triangle_fan_top.sv
// ----------------------------------------------------------------------------
// gauge_sector_triangle_fan_top
// Circular sector triangle fan generator for gauge faces.
// ----------------------------------------------------------------------------
// One sweep is taken when the block is idle; it then emits one triangle per
// step of at most STEP_ANGLE, up to MAX_TRIANGLES. All arithmetic goes through
// a single shared 34x34 multiplier, one operation per cycle: the sweep transfer
// is followed by the centre pass and the first rim point, and each triangle
// then adds an advance, one more rim point and a transfer, plus any output
// stall. The next sweep is taken while the final triangle still waits in the
// output register.
module gauge_sector_triangle_fan_top #(
    parameter int STEP_ANGLE    = gstf_pkg::STEP_ANGLE_DEF,
    parameter int MAX_TRIANGLES = gstf_pkg::MAX_TRIANGLES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gstf_pkg::IDX_W-1:0]       cfg_index,
    input  logic [gstf_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [gstf_pkg::SW_W-1:0] sweep,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [15:0]               p1_x,
    output logic signed [15:0]               p1_y,
    output logic signed [15:0]               p2_x,
    output logic signed [15:0]               p2_y,
    output logic signed [15:0]               p3_x,
    output logic signed [15:0]               p3_y,
    output logic [31:0]                      uv_first,
    output logic [31:0]                      uv_second,
    output logic [31:0]                      uv_third,
    output logic                             last_triangle
);
    import gstf_pkg::*;

    gstf_cmd_t  cmd;
    gstf_stat_t stat;

    gstf_ctrl #(
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    gstf_datapath #(
        .STEP_ANGLE (STEP_ANGLE)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sweep         (sweep),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .p1_x          (p1_x),
        .p1_y          (p1_y),
        .p2_x          (p2_x),
        .p2_y          (p2_y),
        .p3_x          (p3_x),
        .p3_y          (p3_y),
        .uv_first      (uv_first),
        .uv_second     (uv_second),
        .uv_third      (uv_third),
        .last_triangle (last_triangle)
    );

endmodule

>>> hw/rtl/gstf_ctrl.sv
// ----------------------------------------------------------------------------
// gstf_ctrl
// Sequencer: steps the datapath through the centre pass, a first rim point,
// then one rim point per triangle, the fan advance and the result transfer.
// ----------------------------------------------------------------------------
module gstf_ctrl #(
    parameter int MAX_TRIANGLES = gstf_pkg::MAX_TRIANGLES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  gstf_pkg::gstf_stat_t stat,
    output gstf_pkg::gstf_cmd_t  cmd
);
    import gstf_pkg::*;

    localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CENTER = 3'd1;
    localparam logic [2:0] S_RIM    = 3'd2;
    localparam logic [2:0] S_ADV    = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              first_reg, first_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        cmd        = '0;
        cmd.op     = OP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_CENTER;
                    step_next  = PROG_CTR;
                    cnt_next   = '0;
                    first_next = 1'b1;
                end
            end
            S_CENTER:
            begin
                cmd.op     = prog_op(step_reg);
                cmd.centre = 1'b1;
                if (step_reg == PROG_LAST)
                begin
                    state_next = S_RIM;
                    step_next  = '0;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            S_RIM:
            begin
                cmd.op = prog_op(step_reg);
                if (step_reg == PROG_LAST)
                begin
                    first_next = 1'b0;
                    state_next = first_reg ? S_ADV : S_EMIT;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            S_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = S_RIM;
                step_next   = '0;
            end
            S_EMIT:
            begin
                cmd.last = stat.rem_zero || (cnt_reg == CNT_W'(MAX_TRIANGLES - 1));
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = cmd.last ? S_IDLE : S_ADV;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            cnt_reg   <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
        end
    end

endmodule

>>> hw/rtl/gstf_datapath.sv
// ----------------------------------------------------------------------------
// gstf_datapath
// Configuration registers, fan state, one shared 34x34 multiplier with its
// operand select, the sine/cosine and scaling registers, and the result
// register.
// ----------------------------------------------------------------------------
module gstf_datapath #(
    parameter int STEP_ANGLE = gstf_pkg::STEP_ANGLE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gstf_pkg::IDX_W-1:0]          cfg_index,
    input  logic [gstf_pkg::CFG_W-1:0]          cfg_data,
    input  logic signed [gstf_pkg::SW_W-1:0]    sweep,
    input  gstf_pkg::gstf_cmd_t                 cmd,
    output gstf_pkg::gstf_stat_t                stat,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [15:0]                  p1_x,
    output logic signed [15:0]                  p1_y,
    output logic signed [15:0]                  p2_x,
    output logic signed [15:0]                  p2_y,
    output logic signed [15:0]                  p3_x,
    output logic signed [15:0]                  p3_y,
    output logic [31:0]                         uv_first,
    output logic [31:0]                         uv_second,
    output logic [31:0]                         uv_third,
    output logic                                last_triangle
);
    import gstf_pkg::*;

    localparam logic signed [ANG_W-1:0] STEP_S = ANG_W'(STEP_ANGLE);

    logic [CRD_W-1:0]        cx_reg, cy_reg, rad_reg;
    logic signed [SW_W-1:0]  start_reg;
    logic signed [ANG_W-1:0] angle_reg;
    logic signed [SW_W-1:0]  rem_reg;
    logic                    out_valid_reg;

    logic [31:0]             ph_hi_reg;
    logic [31:0]             u_reg;
    logic [1:0]              q_reg;
    logic                    neg_reg;
    logic [29:0]             x_reg, x2_reg, w_reg, s_reg;
    logic [30:0]             t_reg;
    logic signed [45:0]      num_reg;
    logic [22:0]             a_reg;
    logic                    sgn_reg;
    logic signed [SC_W-1:0]  cx_sc_reg, cy_sc_reg, ax_sc_reg, ay_sc_reg, bx_sc_reg, by_sc_reg;

    logic signed [ANG_W-1:0] rem_ext, delta;
    logic signed [SW_W-1:0]  sw_sat;
    logic                    ang_neg;
    logic [ANG_W-1:0]        ang_abs;
    logic [31:0]             u_bias, rd;
    logic [1:0]              qd;
    logic [31:0]             md;
    logic [30:0]             c_mag, cs_mag, sn_mag;
    logic                    cs_neg, sn_neg;
    logic [MUL_W-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]       prod;
    logic [49:0]             p50, pn;
    logic [42:0]             base;
    logic                    trig_neg;
    logic signed [45:0]      num_new;
    logic [45:0]             num_mag, a_sum;
    logic [SC_W-1:0]         q_mag;
    logic signed [SC_W-1:0]  sc_new;

    assign stat.rem_zero = (rem_reg == '0);
    assign stat.out_free = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;

    always_comb
    begin
        rem_ext = ANG_W'(rem_reg);
        if (rem_ext > STEP_S)
            delta = STEP_S;
        else if (rem_ext < -STEP_S)
            delta = -STEP_S;
        else
            delta = rem_ext;

        if (sweep > SW_W'(SWEEP_LIMIT))
            sw_sat = SW_W'(SWEEP_LIMIT);
        else if (sweep < -SW_W'(SWEEP_LIMIT))
            sw_sat = -SW_W'(SWEEP_LIMIT);
        else
            sw_sat = sweep;
    end

    // phase split into quadrant and residual
    always_comb
    begin
        ang_neg = angle_reg[ANG_W-1];
        ang_abs = ang_neg ? ANG_W'(-angle_reg) : ANG_W'(angle_reg);
        u_bias  = u_reg + 32'h2000_0000;
        qd      = u_bias[31:30];
        rd      = u_reg - {qd, 30'b0};
        md      = rd[31] ? (32'd0 - rd) : rd;
        c_mag   = ONE_Q30 - {2'b0, w_reg[29:1]};
    end

    // quadrant rotation as magnitude and sign
    always_comb
    begin
        unique case (q_reg)
            2'd0:
            begin
                cs_mag = c_mag;            cs_neg = 1'b0;
                sn_mag = {1'b0, s_reg};    sn_neg = neg_reg;
            end
            2'd1:
            begin
                cs_mag = {1'b0, s_reg};    cs_neg = !neg_reg;
                sn_mag = c_mag;            sn_neg = 1'b0;
            end
            2'd2:
            begin
                cs_mag = c_mag;            cs_neg = 1'b1;
                sn_mag = {1'b0, s_reg};    sn_neg = !neg_reg;
            end
            default:
            begin
                cs_mag = {1'b0, s_reg};    cs_neg = neg_reg;
                sn_mag = c_mag;            sn_neg = 1'b1;
            end
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_PHH: begin mul_a = MUL_W'(ang_abs);  mul_b = MUL_W'(K_HI);   end
            OP_PHL: begin mul_a = MUL_W'(ang_abs);  mul_b = MUL_W'(K_LO);   end
            OP_X:   begin mul_a = MUL_W'(md);       mul_b = MUL_W'(PI_Q30); end
            OP_X2:  begin mul_a = MUL_W'(x_reg);    mul_b = MUL_W'(x_reg);  end
            OP_T42: begin mul_a = MUL_W'(x2_reg);   mul_b = M42;            end
            OP_T56: begin mul_a = MUL_W'(x2_reg);   mul_b = M56;            end
            OP_T20: begin mul_a = MUL_W'(w_reg);    mul_b = M20;            end
            OP_T6:  begin mul_a = MUL_W'(w_reg);    mul_b = M6;             end
            OP_T30: begin mul_a = MUL_W'(w_reg);    mul_b = M30;            end
            OP_T12: begin mul_a = MUL_W'(w_reg);    mul_b = M12;            end
            OP_W:   begin mul_a = MUL_W'(x2_reg);   mul_b = MUL_W'(t_reg);  end
            OP_S:   begin mul_a = MUL_W'(x_reg);    mul_b = MUL_W'(t_reg);  end
            OP_RX:
            begin
                mul_a = MUL_W'(rad_reg);
                mul_b = cmd.centre ? '0 : MUL_W'(cs_mag);
            end
            OP_RY:
            begin
                mul_a = MUL_W'(rad_reg);
                mul_b = cmd.centre ? '0 : MUL_W'(sn_mag);
            end
            OP_QX, OP_QY:
            begin
                mul_a = MUL_W'(a_reg);
                mul_b = MUL_W'(M25);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        p50      = {ph_hi_reg, 18'b0} + prod[49:0];
        pn       = ang_neg ? (50'd0 - p50) : p50;
        base     = (cmd.op == OP_RY) ? {cy_reg, 30'b0} : {cx_reg, 30'b0};
        trig_neg = (cmd.op == OP_RY) ? sn_neg : cs_neg;
        num_new  = trig_neg ? ($signed({3'b0, base}) - $signed({2'b0, prod[43:0]}))
                            : ($signed({3'b0, base}) + $signed({2'b0, prod[43:0]}));
        num_mag  = num_reg[45] ? 46'(-num_reg) : 46'(num_reg);
        a_sum    = num_mag + RND_BIAS;
        q_mag    = prod[SC_W+26:27];
        sc_new   = sgn_reg ? -$signed(q_mag) : $signed(q_mag);
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_PHH: ph_hi_reg <= prod[31:0];
            OP_PHL: u_reg <= pn[47:16];
            OP_X:
            begin
                x_reg   <= prod[60:31];
                q_reg   <= qd;
                neg_reg <= rd[31];
            end
            OP_X2: x2_reg <= prod[59:30];
            OP_T42, OP_T20, OP_T6, OP_T56, OP_T30, OP_T12:
                t_reg <= ONE_Q30 - prod[66:36];
            OP_W:  w_reg <= prod[59:30];
            OP_S:  s_reg <= prod[59:30];
            OP_RX, OP_RY: num_reg <= num_new;
            OP_AX, OP_AY:
            begin
                a_reg   <= a_sum[45:23];
                sgn_reg <= num_reg[45];
            end
            OP_QX:
            begin
                if (cmd.centre)
                    cx_sc_reg <= sc_new;
                else
                    bx_sc_reg <= sc_new;
            end
            OP_QY:
            begin
                if (cmd.centre)
                    cy_sc_reg <= sc_new;
                else
                    by_sc_reg <= sc_new;
            end
            default:
            begin
            end
        endcase

        // previous rim point becomes the first of the next triangle
        if (cmd.advance)
        begin
            ax_sc_reg <= bx_sc_reg;
            ay_sc_reg <= by_sc_reg;
        end

        if (cmd.emit)
        begin
            p1_x          <= pos_sat(cx_sc_reg);
            p1_y          <= pos_sat(cy_sc_reg);
            p2_x          <= pos_sat(ax_sc_reg);
            p2_y          <= pos_sat(ay_sc_reg);
            p3_x          <= pos_sat(bx_sc_reg);
            p3_y          <= pos_sat(by_sc_reg);
            uv_first      <= {uv_sat(cx_sc_reg), uv_sat(cy_sc_reg)};
            uv_second     <= {uv_sat(ax_sc_reg), uv_sat(ay_sc_reg)};
            uv_third      <= {uv_sat(bx_sc_reg), uv_sat(by_sc_reg)};
            last_triangle <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg        <= CRD_W'(3200);
            cy_reg        <= CRD_W'(3200);
            rad_reg       <= CRD_W'(1600);
            start_reg     <= '0;
            angle_reg     <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CENTER_X:    cx_reg    <= cfg_data[CRD_W-1:0];
                    CFG_CENTER_Y:    cy_reg    <= cfg_data[CRD_W-1:0];
                    CFG_OUTER_RAD:   rad_reg   <= cfg_data[CRD_W-1:0];
                    CFG_START_ANGLE: start_reg <= $signed(cfg_data);
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.start)
            begin
                angle_reg <= ANG_W'(start_reg);
                rem_reg   <= sw_sat;
            end
            else if (cmd.advance)
            begin
                angle_reg <= angle_reg + delta;
                rem_reg   <= SW_W'(rem_ext - delta);
            end

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

endmodule
